// File: rtl/mma_pkg.sv
`default_nettype none

package mma_pkg;

	// Element format: signed Q8.8.
	localparam int ELEM_W     = 16;
	localparam int GAIN_W     = 16;
	localparam int FRAC_SHIFT = 16;
	// Old C is Q8.8 and the product sum is Q16.16, so C is aligned by 8 bits.
	localparam int C_ALIGN    = 8;

	// Stream field widths.
	localparam int IDX_W      = 6;
	localparam int DIM_REG_W  = 4;
	localparam int TDATA_W    = 24;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;
	localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;

	// Register reset values.
	localparam logic [DIM_REG_W-1:0]    DIM_RESET   = 4'd8;
	localparam logic signed [GAIN_W-1:0] ALPHA_RESET = 16'sd256;
	localparam logic signed [GAIN_W-1:0] BETA_RESET  = 16'sd0;

	// Kind of an input word.
	typedef enum logic [1:0] {
		ACT_LOAD_A = 2'd0,
		ACT_LOAD_B = 2'd1,
		ACT_LOAD_C = 2'd2,
		ACT_START  = 2'd3
	} action_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;
		logic             issue;
		logic             first;
		logic             last_term;
		logic [IDX_W-1:0] a_addr;
		logic [IDX_W-1:0] b_addr;
		logic [IDX_W-1:0] c_idx;
		logic             last_elem;
	} mma_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic res_done;
		logic out_free;
	} mma_status_t;

endpackage

`default_nettype wire

// File: rtl/mma_ctrl.sv
`default_nettype none

module mma_ctrl import mma_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire action_t              s_action,
	input  wire logic [DIM_REG_W-1:0] rows_m,
	input  wire logic [DIM_REG_W-1:0] cols_n,
	input  wire logic [DIM_REG_W-1:0] inner_k,
	input  wire logic                 transpose_a,
	input  wire logic                 transpose_b,
	input  wire mma_status_t          st,
	output logic                      s_tready,
	output mma_cmd_t                  cmd
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_MAC,
		ST_WAIT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  i_q, j_q, t_q;
	logic [IDX_W-1:0]  a_row_q, a_addr_q, b_col_q, b_addr_q, c_idx_q;
	logic [DIM_W-1:0]  m_eff, n_eff, k_eff;
	logic [IDX_W-1:0]  a_t_step, a_row_step, b_t_step, b_col_step;
	logic [IDX_W-1:0]  a_row_nxt, b_col_nxt;
	logic              last_i, last_j, last_t;
	logic              start_acc;

	// A dimension of zero counts as one, any above the maximum as the maximum.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d == '0) begin
			r = DIM_W'(1);
		end else if (d > DIM_REG_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = d[DIM_W-1:0];
		end
		return r;
	endfunction

	assign m_eff = clamp_dim(rows_m);
	assign n_eff = clamp_dim(cols_n);
	assign k_eff = clamp_dim(inner_k);

	// Address steps follow the storage layout of each operand.
	assign a_t_step   = transpose_a ? IDX_W'(m_eff) : IDX_W'(1);
	assign a_row_step = transpose_a ? IDX_W'(1) : IDX_W'(k_eff);
	assign b_t_step   = transpose_b ? IDX_W'(1) : IDX_W'(n_eff);
	assign b_col_step = transpose_b ? IDX_W'(k_eff) : IDX_W'(1);
	assign a_row_nxt  = a_row_q + a_row_step;
	assign b_col_nxt  = b_col_q + b_col_step;

	assign last_i = (DIM_W'(i_q) == m_eff - DIM_W'(1));
	assign last_j = (DIM_W'(j_q) == n_eff - DIM_W'(1));
	assign last_t = (DIM_W'(t_q) == k_eff - DIM_W'(1));

	assign s_tready  = (state_q == ST_IDLE);
	assign start_acc = s_tvalid && s_tready && (s_action == ACT_START);

	always_comb begin
		cmd.load      = s_tvalid && s_tready && (s_action != ACT_START);
		cmd.issue     = (state_q == ST_MAC);
		cmd.first     = (t_q == '0);
		cmd.last_term = last_t;
		cmd.a_addr    = a_addr_q;
		cmd.b_addr    = b_addr_q;
		cmd.c_idx     = c_idx_q;
		cmd.last_elem = last_i && last_j;
	end

	// Sequencer: one C element at a time, one product term per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			t_q      <= '0;
			a_row_q  <= '0;
			a_addr_q <= '0;
			b_col_q  <= '0;
			b_addr_q <= '0;
			c_idx_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start_acc) begin
						i_q      <= '0;
						j_q      <= '0;
						t_q      <= '0;
						a_row_q  <= '0;
						a_addr_q <= '0;
						b_col_q  <= '0;
						b_addr_q <= '0;
						c_idx_q  <= '0;
						state_q  <= ST_PREP;
					end
				end
				ST_PREP: begin
					// The output register must be free before the result arrives.
					if (st.out_free) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (last_t) begin
						state_q <= ST_WAIT;
					end else begin
						t_q      <= t_q + CNT_W'(1);
						a_addr_q <= a_addr_q + a_t_step;
						b_addr_q <= b_addr_q + b_t_step;
					end
				end
				ST_WAIT: begin
					if (st.res_done) begin
						t_q     <= '0;
						c_idx_q <= c_idx_q + IDX_W'(1);
						if (last_i && last_j) begin
							state_q <= ST_IDLE;
						end else if (last_j) begin
							i_q      <= i_q + CNT_W'(1);
							j_q      <= '0;
							a_row_q  <= a_row_nxt;
							a_addr_q <= a_row_nxt;
							b_col_q  <= '0;
							b_addr_q <= '0;
							state_q  <= ST_PREP;
						end else begin
							j_q      <= j_q + CNT_W'(1);
							a_addr_q <= a_row_q;
							b_col_q  <= b_col_nxt;
							b_addr_q <= b_col_nxt;
							state_q  <= ST_PREP;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/mma_dp.sv
`default_nettype none

module mma_dp import mma_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mma_cmd_t                 cmd,
	input  wire action_t                  in_action,
	input  wire logic [IDX_W-1:0]         in_index,
	input  wire logic signed [ELEM_W-1:0] in_value,
	input  wire logic signed [GAIN_W-1:0] alpha_gain,
	input  wire logic signed [GAIN_W-1:0] beta_gain,
	input  wire logic                     m_tready,
	output mma_status_t                   st,
	output logic                          out_valid,
	output logic signed [ELEM_W-1:0]      out_value,
	output logic [IDX_W-1:0]              out_index,
	output logic                          out_last,
	output logic                          out_sat
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int SUM_W  = PROD_W + $clog2(MAX_DIM);
	localparam int SCL_W  = GAIN_W + SUM_W;
	localparam int CT_W   = GAIN_W + ELEM_W;
	localparam int ACC_W  = SCL_W + 1;
	localparam int SHR_W  = ACC_W - FRAC_SHIFT;

	logic signed [ELEM_W-1:0] a_mem [DEPTH];
	logic signed [ELEM_W-1:0] b_mem [DEPTH];
	logic signed [ELEM_W-1:0] c_mem [DEPTH];
	logic [DEPTH-1:0]         c_vld_q;

	logic signed [ELEM_W-1:0] a_rd_s1, b_rd_s1, c_rd_q, c_old;
	logic                     c_ok_q;
	logic                     v_s1, f_s1, lk_s1, v_s2, f_s2, lk_s2, done_s3, v_s4;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [SCL_W-1:0]  scaled_s4;
	logic signed [CT_W-1:0]   cterm_s4;
	logic signed [ACC_W-1:0]  acc;
	logic signed [SHR_W-1:0]  shr;
	logic signed [ELEM_W-1:0] res_val;
	logic                     res_sat;
	logic                     load_ok;
	logic                     c_we;
	logic [IDX_W-1:0]         c_wa;
	logic signed [ELEM_W-1:0] c_wd;
	logic                     out_valid_q;

	// Loads beyond the store depth are dropped.
	assign load_ok = cmd.load && ({1'b0, in_index} < (IDX_W + 1)'(DEPTH));

	// A and B stores: written by loads, read once per product term.
	always_ff @(posedge clk) begin
		if (load_ok && in_action == ACT_LOAD_A) begin
			a_mem[in_index[ADDR_W-1:0]] <= in_value;
		end
		if (load_ok && in_action == ACT_LOAD_B) begin
			b_mem[in_index[ADDR_W-1:0]] <= in_value;
		end
		if (cmd.issue) begin
			a_rd_s1 <= a_mem[cmd.a_addr[ADDR_W-1:0]];
			b_rd_s1 <= b_mem[cmd.b_addr[ADDR_W-1:0]];
		end
	end

	// The C store takes either a load or the write-back of a new element.
	always_comb begin
		if (v_s4) begin
			c_we = 1'b1;
			c_wa = cmd.c_idx;
			c_wd = res_val;
		end else begin
			c_we = load_ok && (in_action == ACT_LOAD_C);
			c_wa = in_index;
			c_wd = in_value;
		end
	end

	always_ff @(posedge clk) begin
		if (c_we) begin
			c_mem[c_wa[ADDR_W-1:0]] <= c_wd;
		end
		if (cmd.issue && cmd.first) begin
			c_rd_q <= c_mem[cmd.c_idx[ADDR_W-1:0]];
		end
	end

	// Entry valid bits give the all-zero reset contents of the C store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_vld_q <= '0;
			c_ok_q  <= 1'b0;
		end else begin
			if (c_we) begin
				c_vld_q[c_wa[ADDR_W-1:0]] <= 1'b1;
			end
			if (cmd.issue && cmd.first) begin
				c_ok_q <= c_vld_q[cmd.c_idx[ADDR_W-1:0]];
			end
		end
	end

	assign c_old = c_ok_q ? c_rd_q : '0;

	// Pipeline tags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			f_s1    <= 1'b0;
			lk_s1   <= 1'b0;
			v_s2    <= 1'b0;
			f_s2    <= 1'b0;
			lk_s2   <= 1'b0;
			done_s3 <= 1'b0;
			v_s4    <= 1'b0;
		end else begin
			v_s1    <= cmd.issue;
			f_s1    <= cmd.first;
			lk_s1   <= cmd.last_term;
			v_s2    <= v_s1;
			f_s2    <= f_s1;
			lk_s2   <= lk_s1;
			done_s3 <= v_s2 && lk_s2;
			v_s4    <= done_s3;
		end
	end

	// Multiply, accumulate, then scale by alpha and beta.
	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * b_rd_s1;
		if (v_s2) begin
			if (f_s2) begin
				sum_q <= SUM_W'(prod_s2);
			end else begin
				sum_q <= sum_q + SUM_W'(prod_s2);
			end
		end
		if (done_s3) begin
			scaled_s4 <= alpha_gain * sum_q;
			cterm_s4  <= beta_gain * c_old;
		end
	end

	// Combine, floor-shift to Q8.8 and saturate.
	always_comb begin
		acc = ACC_W'(scaled_s4) + (ACC_W'(cterm_s4) <<< C_ALIGN);
		shr = $signed(acc[ACC_W-1:FRAC_SHIFT]);
		priority if (shr > SHR_W'(ELEM_MAX)) begin
			res_val = ELEM_MAX;
			res_sat = 1'b1;
		end else if (shr < SHR_W'(ELEM_MIN)) begin
			res_val = ELEM_MIN;
			res_sat = 1'b1;
		end else begin
			res_val = shr[ELEM_W-1:0];
			res_sat = 1'b0;
		end
	end

	// Output register: holds a word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (v_s4) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			out_value <= res_val;
			out_index <= cmd.c_idx;
			out_last  <= cmd.last_elem;
			out_sat   <= res_sat;
		end
	end

	assign out_valid   = out_valid_q;
	assign st.res_done = v_s4;
	assign st.out_free = !out_valid_q || m_tready;

endmodule

`default_nettype wire

// File: rtl/matrix_multiply_accumulate_unit.sv
`default_nettype none

// Matrix multiply-accumulate unit: C = alpha*op(A)*op(B) + beta*C in signed Q8.8.
// Load words (tuser 0, 1, 2 for A, B, C) write one element each and are taken one
// per cycle; loads at an index of MAX_DIM*MAX_DIM or more are dropped. A start word
// (tuser 3) makes the unit stream every C element in row-major order with tlast on
// the final one and tuser high where the result saturated; each result is also
// written back to the C store. Each element passes its K terms, one per cycle,
// through the read and product stages and the single multiply-accumulate unit,
// then the scaling and output stages. The output can stall a run, and no input is
// taken while a start runs. The C store reads as zero after reset; A and B entries
// must be loaded before use. Registers sit at byte address 4*i: rows_m, cols_n,
// inner_k, transpose_a, transpose_b, alpha_gain, beta_gain; the user must write
// them only while idle, as the unit itself does not enforce this.
module matrix_multiply_accumulate_unit import mma_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// s_tdata: element_index[5:0], element_value[21:6], zero pad [23:22]
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [TDATA_W-1:0]    s_tdata,
	// s_tuser: action[1:0]
	input  wire logic [1:0]            s_tuser,
	// m_tdata: result_value[15:0], result_index[21:16], zero pad [23:22]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [TDATA_W-1:0]         m_tdata,
	output logic                       m_tlast,
	// m_tuser: saturated[0]
	output logic                       m_tuser,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	typedef enum logic [2:0] {
		REG_ROWS_M      = 3'd0,
		REG_COLS_N      = 3'd1,
		REG_INNER_K     = 3'd2,
		REG_TRANSPOSE_A = 3'd3,
		REG_TRANSPOSE_B = 3'd4,
		REG_ALPHA_GAIN  = 3'd5,
		REG_BETA_GAIN   = 3'd6
	} reg_idx_t;

	logic [DIM_REG_W-1:0]     rows_m_q, cols_n_q, inner_k_q;
	logic                     transpose_a_q, transpose_b_q;
	logic signed [GAIN_W-1:0] alpha_gain_q, beta_gain_q;
	reg_idx_t                 reg_sel;
	logic                     reg_wr;

	mma_cmd_t                 cmd;
	mma_status_t              st;
	logic signed [ELEM_W-1:0] out_value;
	logic [IDX_W-1:0]         out_index;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[4:2]);
	assign reg_wr  = psel && penable && pwrite && pready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q      <= DIM_RESET;
			cols_n_q      <= DIM_RESET;
			inner_k_q     <= DIM_RESET;
			transpose_a_q <= 1'b0;
			transpose_b_q <= 1'b0;
			alpha_gain_q  <= ALPHA_RESET;
			beta_gain_q   <= BETA_RESET;
		end else if (reg_wr) begin
			unique case (reg_sel)
				REG_ROWS_M:      rows_m_q      <= pwdata[DIM_REG_W-1:0];
				REG_COLS_N:      cols_n_q      <= pwdata[DIM_REG_W-1:0];
				REG_INNER_K:     inner_k_q     <= pwdata[DIM_REG_W-1:0];
				REG_TRANSPOSE_A: transpose_a_q <= pwdata[0];
				REG_TRANSPOSE_B: transpose_b_q <= pwdata[0];
				REG_ALPHA_GAIN:  alpha_gain_q  <= pwdata[GAIN_W-1:0];
				REG_BETA_GAIN:   beta_gain_q   <= pwdata[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_sel)
			REG_ROWS_M:      prdata = APB_DATA_W'(rows_m_q);
			REG_COLS_N:      prdata = APB_DATA_W'(cols_n_q);
			REG_INNER_K:     prdata = APB_DATA_W'(inner_k_q);
			REG_TRANSPOSE_A: prdata = APB_DATA_W'(transpose_a_q);
			REG_TRANSPOSE_B: prdata = APB_DATA_W'(transpose_b_q);
			REG_ALPHA_GAIN:  prdata = APB_DATA_W'(alpha_gain_q);
			REG_BETA_GAIN:   prdata = APB_DATA_W'(beta_gain_q);
			default:         prdata = '0;
		endcase
	end

	mma_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_action    (action_t'(s_tuser)),
		.rows_m      (rows_m_q),
		.cols_n      (cols_n_q),
		.inner_k     (inner_k_q),
		.transpose_a (transpose_a_q),
		.transpose_b (transpose_b_q),
		.st          (st),
		.s_tready    (s_tready),
		.cmd         (cmd)
	);

	mma_dp #(
		.MAX_DIM(MAX_DIM)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_action  (action_t'(s_tuser)),
		.in_index   (s_tdata[IDX_W-1:0]),
		.in_value   (s_tdata[IDX_W+ELEM_W-1:IDX_W]),
		.alpha_gain (alpha_gain_q),
		.beta_gain  (beta_gain_q),
		.m_tready   (m_tready),
		.st         (st),
		.out_valid  (m_tvalid),
		.out_value  (out_value),
		.out_index  (out_index),
		.out_last   (m_tlast),
		.out_sat    (m_tuser)
	);

	assign m_tdata = {(TDATA_W - IDX_W - ELEM_W)'(0), out_index, out_value};

`ifndef SYNTH
	// A finished element must never land on an output word still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		st.res_done |-> (!m_tvalid || m_tready))
		else $error("result overwrote a pending output word");

	// No input word is taken while a finished element is written back.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> !st.res_done)
		else $error("input taken while a result was in flight");

	// A start word closes the input right after it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == ACT_START) |=> !s_tready)
		else $error("input stayed open after a start word");
`endif

endmodule

`default_nettype wire
